// ----- sv/tfrc_pkg.sv -----
package tfrc_pkg;

    localparam int RTT_W  = 24;
    localparam int LOSS_W = 17;
    localparam int RECV_W = 32;
    localparam int RATE_W = 33;
    localparam int PKT_W  = 16;
    localparam int L2_W   = 33;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    // quotient bits kept by the divider, enough to cover twice the receive rate
    localparam int QB = 34;

    localparam logic [LOSS_W-1:0] LOSS_ONE   = 17'd65536;
    localparam logic [PKT_W-1:0]  PKT_RESET  = 16'd1200;
    localparam logic [22:0]       NUM_SCALE  = 23'd8000000;
    // ceil(2^19 / 3), exact quotient by three for values up to 2^17
    localparam logic [17:0]       RECIP3     = 18'd174763;
    localparam int                RECIP3_SH  = 19;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_RTT = 1'b1;

    typedef struct packed {
        logic [RTT_W-1:0]  rtt;
        logic [LOSS_W-1:0] loss;
        logic [L2_W-1:0]   loss_sq;
        logic [RATE_W-1:0] upper;
        logic              zero_loss;
        logic              zero_rtt;
    } side_t;

    typedef struct packed {
        logic              status;
        logic [RATE_W-1:0] rate;
    } result_t;

endpackage

// ----- sv/tfrc_delay.sv -----
module tfrc_delay #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ce,
    input  logic              valid_in,
    input  tfrc_pkg::side_t   side_in,
    output logic              valid_out,
    output tfrc_pkg::side_t   side_out
);

    logic            valid_reg [DEPTH];
    tfrc_pkg::side_t side_reg  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_tap
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (ce) begin
                valid_reg[i] <= (i == 0) ? valid_in : valid_reg[(i == 0) ? 0 : i - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                side_reg[i] <= (i == 0) ? side_in : side_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign valid_out = valid_reg[DEPTH-1];
    assign side_out  = side_reg[DEPTH-1];

endmodule

// ----- sv/tfrc_isqrt.sv -----
module tfrc_isqrt #(
    parameter int RW = 20
) (
    input  logic            aclk,
    input  logic            ce,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] x_reg    [RW];

    for (genvar i = 0; i < RW; i++) begin : g_step
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] x_in;
        logic [RW+1:0]   rem_sh;
        logic [RW+1:0]   trial;
        logic            ge;
        logic [RW+1:0]   rem_next;
        logic [RW-1:0]   root_next;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = radicand;
        end else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign x_in    = x_reg[i-1];
        end

        // one root bit per step, two radicand bits shifted in
        assign rem_sh    = {rem_in[RW-1:0], x_in[2*RW-1:2*RW-2]};
        assign trial     = {root_in, 2'b01};
        assign ge        = (rem_sh >= trial);
        assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_in[RW-2:0], ge};

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                x_reg[i]    <= {x_in[2*RW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ----- sv/tfrc_div.sv -----
module tfrc_div #(
    parameter int DW = 54,
    parameter int NW = 59,
    parameter int QW = 34
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [DW-1:0] divisor,
    input  logic [NW-1:0] dividend,
    output logic [QW-1:0] quotient,
    output logic          saturated
);

    logic [NW-QW-1:0] head;
    logic [DW-1:0]    rem_reg  [QW+1];
    logic [DW-1:0]    d_reg    [QW+1];
    logic [QW-1:0]    q_reg    [QW+1];
    logic             sat_reg  [QW+1];

    // head stage: quotient too large for the kept bits
    assign head = dividend[NW-1:QW];

    always_ff @(posedge aclk) begin
        if (ce) begin
            sat_reg[0] <= (DW'(head) >= divisor);
            rem_reg[0] <= DW'(head);
            d_reg[0]   <= divisor;
            q_reg[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [DW:0]   rem_sh;
        logic          ge;
        logic [DW:0]   rem_next;

        assign rem_sh   = {rem_reg[j], dividend[QW-1-j]};
        assign ge       = (rem_sh >= {1'b0, d_reg[j]});
        assign rem_next = ge ? (rem_sh - {1'b0, d_reg[j]}) : rem_sh;

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j+1] <= rem_next[DW-1:0];
                d_reg[j+1]   <= d_reg[j];
                q_reg[j+1]   <= {q_reg[j][QW-2:0], ge};
                sat_reg[j+1] <= sat_reg[j];
            end
        end
    end

    assign quotient  = q_reg[QW];
    assign saturated = sat_reg[QW];

endmodule

// ----- sv/tfrc_out_slice.sv -----
module tfrc_out_slice (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tfrc_pkg::result_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tfrc_pkg::result_t   out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    tfrc_pkg::result_t out_data_reg;
    tfrc_pkg::result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ----- sv/tfrc_rate_equation.sv -----
// TFRC allowed send rate unit, one result beat for every input beat.
// Input beats on s_* carry the round-trip time in microseconds, the loss
// event rate as Q1.16 and the measured receive rate; result beats on m_*
// carry the allowed rate in bit/s and a status flag in m_tuser (set for a
// zero round-trip time, rate then zero). The segment size is written on the
// cfg_* channel, which is ready whenever out of reset; the user must write
// it only while no beat is in flight, which the block does not enforce.
// From input beat to result beat a beat passes three front stages,
// FRAC_BITS square root steps, four multiply stages and a restoring
// divider of 35 stages, then the output register. While m_tready stays
// high, one beat enters per cycle and one leaves per cycle, the root and
// divider pipelines taking one bit per stage.
// When m_tready is low the result waits in the output register and one more
// beat lands in a skid register; s_tready then drops and the whole pipeline
// holds, nothing lost or repeated. Reset empties the pipeline and sets the
// segment size to 1200 bytes.
module tfrc_rate_equation #(
    parameter int FRAC_BITS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rtt_us, loss_fraction, recv_rate_bps
    input  logic [tfrc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // allowed_rate_bps
    output logic [tfrc_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic                           m_tuser,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tfrc_pkg::PKT_W-1:0]     cfg_data
);

    localparam int RW   = FRAC_BITS;
    localparam int XW   = 2 * FRAC_BITS;
    localparam int SH   = 2 * FRAC_BITS - 16;
    localparam int X2SH = 2 * FRAC_BITS - 19;
    localparam int KW   = FRAC_BITS + 10;
    localparam int DW   = FRAC_BITS + 34;
    localparam int NW   = FRAC_BITS + 39;
    localparam logic [XW-1:0] THIRD1 = XW'((64'd1 << SH) / 3);
    localparam logic [XW-1:0] THIRD2 = XW'((64'd2 << SH) / 3);

    logic ce;
    logic [tfrc_pkg::PKT_W-1:0] pkt_reg;
    logic [NW-1:0]              num_reg;
    logic [38:0]                num_base;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg <= tfrc_pkg::PKT_RESET;
        end else if (cfg_valid) begin
            pkt_reg <= cfg_data;
        end
    end

    assign num_base = 39'(pkt_reg) * 39'(tfrc_pkg::NUM_SCALE);

    always_ff @(posedge aclk) begin
        num_reg <= {num_base, {FRAC_BITS{1'b0}}};
    end

    // stage a: unpack, saturate loss
    logic [tfrc_pkg::RTT_W-1:0]  in_rtt;
    logic [tfrc_pkg::LOSS_W-1:0] in_loss;
    logic [tfrc_pkg::RECV_W-1:0] in_recv;
    tfrc_pkg::side_t             a_side_next;
    tfrc_pkg::side_t             a_side_reg;
    logic                        a_valid_reg;

    assign in_rtt  = s_tdata[23:0];
    assign in_loss = s_tdata[40:24];
    assign in_recv = s_tdata[72:41];

    always_comb begin
        a_side_next.rtt       = in_rtt;
        a_side_next.loss      = (in_loss > tfrc_pkg::LOSS_ONE) ? tfrc_pkg::LOSS_ONE : in_loss;
        a_side_next.loss_sq   = '0;
        a_side_next.upper     = {in_recv, 1'b0};
        a_side_next.zero_loss = (in_loss == '0);
        a_side_next.zero_rtt  = (in_rtt == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_side_reg <= a_side_next;
        end
    end

    // stage b: 2p/3 split into quotient and remainder, 3p/8 radicand, p^2
    logic [17:0]     b_two_l;
    logic [17:0]     b_three_l;
    logic [35:0]     b_recip;
    logic [15:0]     b_q3_next;
    logic [17:0]     b_chk;
    logic [33:0]     b_sq;
    tfrc_pkg::side_t b_side_next;
    logic            b_valid_reg;
    tfrc_pkg::side_t b_side_reg;
    logic [15:0]     b_q3_reg;
    logic [1:0]      b_rem_reg;
    logic [XW-1:0]   b_x2_reg;

    assign b_two_l   = {a_side_reg.loss, 1'b0};
    assign b_three_l = b_two_l + {1'b0, a_side_reg.loss};
    assign b_recip   = 36'(b_two_l) * 36'(tfrc_pkg::RECIP3);
    assign b_q3_next = b_recip[tfrc_pkg::RECIP3_SH+15:tfrc_pkg::RECIP3_SH];
    assign b_chk     = b_two_l - (18'(b_q3_next) * 18'd3);
    assign b_sq      = 34'(a_side_reg.loss) * 34'(a_side_reg.loss);

    always_comb begin
        b_side_next         = a_side_reg;
        b_side_next.loss_sq = b_sq[tfrc_pkg::L2_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_side_reg <= b_side_next;
            b_q3_reg   <= b_q3_next;
            b_rem_reg  <= b_chk[1:0];
            b_x2_reg   <= XW'(b_three_l) << X2SH;
        end
    end

    // stage c: 2p/3 radicand
    logic [XW-1:0]   c_frac;
    logic            c_valid_reg;
    tfrc_pkg::side_t c_side_reg;
    logic [XW-1:0]   c_x1_reg;
    logic [XW-1:0]   c_x2_reg;

    always_comb begin
        unique case (b_rem_reg)
            2'd1:    c_frac = THIRD1;
            2'd2:    c_frac = THIRD2;
            default: c_frac = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_side_reg <= b_side_reg;
            c_x1_reg   <= (XW'(b_q3_reg) << SH) + c_frac;
            c_x2_reg   <= b_x2_reg;
        end
    end

    // square roots
    logic [RW-1:0]   s1;
    logic [RW-1:0]   s2;
    logic            r_valid;
    tfrc_pkg::side_t r_side;

    tfrc_isqrt #(.RW(RW)) u_sqrt1 (
        .aclk     (aclk),
        .ce       (ce),
        .radicand (c_x1_reg),
        .root     (s1)
    );

    tfrc_isqrt #(.RW(RW)) u_sqrt2 (
        .aclk     (aclk),
        .ce       (ce),
        .radicand (c_x2_reg),
        .root     (s2)
    );

    tfrc_delay #(.DEPTH(RW)) u_side_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .valid_in  (c_valid_reg),
        .side_in   (c_side_reg),
        .valid_out (r_valid),
        .side_out  (r_side)
    );

    // stage d: t1 = s2 * p
    logic [RW+16:0]  d_prod;
    logic            d_valid_reg;
    tfrc_pkg::side_t d_side_reg;
    logic [RW-1:0]   d_s1_reg;
    logic [RW-1:0]   d_t1_reg;

    assign d_prod = (RW+17)'(s2) * (RW+17)'(r_side.loss);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= r_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_side_reg <= r_side;
            d_s1_reg   <= s1;
            d_t1_reg   <= d_prod[RW+15:16];
        end
    end

    // stage e: t1 * p^2
    logic            e_valid_reg;
    tfrc_pkg::side_t e_side_reg;
    logic [RW-1:0]   e_s1_reg;
    logic [RW-1:0]   e_t1_reg;
    logic [RW+32:0]  e_p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (ce) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            e_side_reg <= d_side_reg;
            e_s1_reg   <= d_s1_reg;
            e_t1_reg   <= d_t1_reg;
            e_p_reg    <= (RW+33)'(d_t1_reg) * (RW+33)'(d_side_reg.loss_sq);
        end
    end

    // stage f: k = s1 + 12 * (t1 + t1 * 32p^2)
    logic [RW+5:0]   f_t;
    logic [KW-1:0]   f_k_next;
    logic            f_valid_reg;
    tfrc_pkg::side_t f_side_reg;
    logic [KW-1:0]   f_k_reg;

    assign f_t      = (RW+6)'(e_t1_reg) + e_p_reg[RW+32:27];
    assign f_k_next = KW'(e_s1_reg) + (KW'(f_t) << 3) + (KW'(f_t) << 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (ce) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_side_reg <= e_side_reg;
            f_k_reg    <= f_k_next;
        end
    end

    // stage g: divisor = rtt * k
    logic            g_valid_reg;
    tfrc_pkg::side_t g_side_reg;
    logic [DW-1:0]   g_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (ce) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            g_side_reg <= f_side_reg;
            g_d_reg    <= DW'(f_side_reg.rtt) * DW'(f_k_reg);
        end
    end

    // divider
    logic [tfrc_pkg::QB-1:0] quot;
    logic                    quot_sat;
    logic                    q_valid;
    tfrc_pkg::side_t         q_side;

    tfrc_div #(.DW(DW), .NW(NW), .QW(tfrc_pkg::QB)) u_div (
        .aclk      (aclk),
        .ce        (ce),
        .divisor   (g_d_reg),
        .dividend  (num_reg),
        .quotient  (quot),
        .saturated (quot_sat)
    );

    tfrc_delay #(.DEPTH(tfrc_pkg::QB + 1)) u_side_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .valid_in  (g_valid_reg),
        .side_in   (g_side_reg),
        .valid_out (q_valid),
        .side_out  (q_side)
    );

    // clamp and select
    logic [tfrc_pkg::RATE_W-1:0] lower;
    logic [tfrc_pkg::RATE_W-1:0] capped;
    tfrc_pkg::result_t           res_next;
    tfrc_pkg::result_t           res_out;

    assign lower  = tfrc_pkg::RATE_W'(pkt_reg[15:3]);
    assign capped = (quot_sat || (quot >= {1'b0, q_side.upper})) ? q_side.upper
                                                                : quot[tfrc_pkg::RATE_W-1:0];

    always_comb begin
        priority if (q_side.zero_rtt) begin
            res_next.rate   = '0;
            res_next.status = tfrc_pkg::STATUS_BAD_RTT;
        end else if (q_side.zero_loss) begin
            res_next.rate   = (q_side.upper > lower) ? q_side.upper : lower;
            res_next.status = tfrc_pkg::STATUS_OK;
        end else begin
            res_next.rate   = (capped < lower) ? lower : capped;
            res_next.status = tfrc_pkg::STATUS_OK;
        end
    end

    tfrc_out_slice u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (ce),
        .in_data   (res_next),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign s_tready = ce & aresetn;
    assign m_tdata  = tfrc_pkg::M_TDATA_W'(res_out.rate);
    assign m_tuser  = res_out.status;

endmodule

// ----- dv/testbench.sv -----
module testbench;

    localparam int FRAC = 20;
    localparam int LATENCY = FRAC + 43;
    localparam int CYCLE_LIMIT = 600000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [tfrc_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [tfrc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tfrc_pkg::PKT_W-1:0]     cfg_data = '0;

    tfrc_pkg::result_t          rate_queue[$];
    logic [tfrc_pkg::PKT_W-1:0] seg_bytes = tfrc_pkg::PKT_RESET;
    int                         errors = 0;
    int                         beats_in = 0;
    int                         beats_out = 0;
    int                         cycles = 0;
    int                         send_idle_pct = 0;
    int                         stall_pct = 0;
    int                         hold_cycles = 0;

    tfrc_rate_equation #(.FRAC_BITS(FRAC)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic tfrc_pkg::result_t allowed_rate(logic [tfrc_pkg::RTT_W-1:0] rtt,
                                                       logic [tfrc_pkg::LOSS_W-1:0] loss_in,
                                                       logic [tfrc_pkg::RECV_W-1:0] recv,
                                                       logic [tfrc_pkg::PKT_W-1:0] seg);
        tfrc_pkg::result_t r;
        logic [63:0]  loss, lower, upper, x1, x2, s1, s2, t1, poly, t, k, d, rate, eq;
        logic [127:0] prod, num, quo;
        loss = (loss_in > tfrc_pkg::LOSS_ONE) ? 64'(tfrc_pkg::LOSS_ONE) : 64'(loss_in);
        r.status = tfrc_pkg::STATUS_OK;
        if (rtt == 0) begin
            r.status = tfrc_pkg::STATUS_BAD_RTT;
            r.rate = '0;
            return r;
        end
        lower = 64'(seg) >> 3;
        upper = 64'(recv) << 1;
        if (loss == 0) begin
            rate = (upper > lower) ? upper : lower;
        end else begin
            x1 = (((2 * loss) / 3) << (2 * FRAC - 16)) + ((((2 * loss) % 3) << (2 * FRAC - 16)) / 3);
            x2 = (3 * loss) << (2 * FRAC - 19);
            s1 = int_sqrt(x1);
            s2 = int_sqrt(x2);
            t1 = (s2 * loss) >> 16;
            poly = (64'd1 << 32) + ((loss * loss) << 5);
            prod = 128'(t1) * 128'(poly);
            t = prod[95:32];
            k = s1 + 12 * t;
            d = 64'(rtt) * k;
            num = (128'(seg) * 128'd8000000) << FRAC;
            quo = num / 128'(d);
            eq = (quo > (128'd1 << 40)) ? (64'd1 << 40) : quo[63:0];
            rate = (eq < upper) ? eq : upper;
            if (rate < lower) rate = lower;
        end
        r.rate = rate[tfrc_pkg::RATE_W-1:0];
        return r;
    endfunction

    // receiver ready, with a counted hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // result beat check
    always @(posedge aclk) begin
        tfrc_pkg::result_t exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("tfrc_rate_equation: mismatch");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            beats_out <= beats_out + 1;
            if (rate_queue.size() == 0) begin
                $display("%0t unexpected beat: rate %0d status %0b", $time,
                         m_tdata[tfrc_pkg::RATE_W-1:0], m_tuser);
                errors <= errors + 1;
            end else begin
                exp_r = rate_queue.pop_front();
                if (m_tdata[tfrc_pkg::RATE_W-1:0] !== exp_r.rate) begin
                    $display("%0t rate: expected %0d actual %0d", $time, exp_r.rate,
                             m_tdata[tfrc_pkg::RATE_W-1:0]);
                    errors <= errors + 1;
                end
                if (m_tuser !== exp_r.status) begin
                    $display("%0t status: expected %0b actual %0b", $time, exp_r.status,
                             m_tuser);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic send_beat(logic [tfrc_pkg::RTT_W-1:0] rtt, logic [tfrc_pkg::LOSS_W-1:0] loss,
                             logic [tfrc_pkg::RECV_W-1:0] recv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= tfrc_pkg::S_TDATA_W'({recv, loss, rtt});
        do @(posedge aclk); while (!s_tready);
        rate_queue.push_back(allowed_rate(rtt, loss, recv, seg_bytes));
        beats_in++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (rate_queue.size() != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    task automatic write_seg(logic [tfrc_pkg::PKT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        seg_bytes = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_beat();
        logic [tfrc_pkg::RTT_W-1:0]  rtt;
        logic [tfrc_pkg::LOSS_W-1:0] loss;
        logic [tfrc_pkg::RECV_W-1:0] recv;
        case ($urandom_range(9))
            0: rtt = tfrc_pkg::RTT_W'($urandom_range(0, 16777215));
            1: rtt = tfrc_pkg::RTT_W'($urandom_range(0, 3));
            default: rtt = tfrc_pkg::RTT_W'($urandom_range(1000, 500000));
        endcase
        case ($urandom_range(9))
            0: loss = '0;
            1: loss = tfrc_pkg::LOSS_W'($urandom_range(65536, 131071));
            2: loss = tfrc_pkg::LOSS_W'($urandom_range(1, 64));
            default: loss = tfrc_pkg::LOSS_W'($urandom_range(1, 65536));
        endcase
        recv = $urandom();
        if ($urandom_range(3) == 0) recv = recv >> $urandom_range(31);
        send_beat(rtt, loss, recv);
    endtask

    task automatic test_directed();
        send_beat(0, 1000, 32'hFFFF_FFFF);
        send_beat(0, 0, 0);
        send_beat(1, 0, 0);
        send_beat(1, 0, 32'hFFFF_FFFF);
        send_beat(16777215, 65536, 32'hFFFF_FFFF);
        send_beat(16777215, 1, 32'hFFFF_FFFF);
        send_beat(1, 1, 32'hFFFF_FFFF);
        send_beat(1, 65536, 32'hFFFF_FFFF);
        send_beat(100000, 131071, 32'hFFFF_FFFF);
        send_beat(100000, 65537, 1000);
        send_beat(100000, 6554, 0);
        send_beat(50000, 655, 32'hFFFF_FFFF);
        send_beat(20000, 32768, 5000000);
        send_beat(16777215, 65536, 0);
        drain();
    endtask

    task automatic test_seg_sizes();
        logic [tfrc_pkg::PKT_W-1:0] sizes[5] = '{16'd0, 16'd1, 16'd65535, 16'd7, 16'd1500};
        foreach (sizes[i]) begin
            write_seg(sizes[i]);
            send_beat(1, 0, 0);
            send_beat(10000, 65536, 32'hFFFF_FFFF);
            send_beat(1, 1, 32'hFFFF_FFFF);
            send_beat(0, 100, 7);
            repeat (20) random_beat();
            drain();
        end
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (n) random_beat();
        drain();
        write_seg(tfrc_pkg::PKT_W'($urandom_range(1, 65535)));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 300;
        repeat (150) random_beat();
        drain();
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_seg_sizes();
        test_random(350, 0, 0);
        test_random(350, 68, 0);
        test_random(350, 0, 68);
        test_random(350, 28, 28);
        test_backpressure();
        write_seg(16'd65535);
        test_random(250, 0, 0);
        $display("%0d beats sent, %0d results checked, segment sizes 0 to 65535,",
                 beats_in, beats_out);
        $display("zero rtt, zero and saturated loss, idle and stall phases, long hold-off");
        if (errors == 0 && rate_queue.size() == 0) begin
            $display("tfrc_rate_equation: match");
        end else begin
            $display("tfrc_rate_equation: mismatch");
        end
        $finish;
    end
endmodule
